[src/qabm_pkg.sv]
// Shared types, symbol codes and character decode for the bracket matcher.
package qabm_pkg;

	typedef enum logic [2:0] {
		SYM_NONE   = 3'd0,
		SYM_ROUND  = 3'd1,
		SYM_SQUARE = 3'd2,
		SYM_CURLY  = 3'd3,
		SYM_DQUOTE = 3'd4,
		SYM_SQUOTE = 3'd5
	} sym_t;

	typedef enum logic [2:0] {
		ST_MATCHED     = 3'd0,
		ST_WRONG_KIND  = 3'd1,
		ST_UNBALANCED  = 3'd2,
		ST_END_OF_TEXT = 3'd3,
		ST_OVERFLOW    = 3'd4
	} status_t;

	localparam int unsigned CHAR_W = 16;
	localparam int unsigned POS_W  = 31;

	localparam logic [CHAR_W-1:0] CH_DQUOTE   = 16'h0022;
	localparam logic [CHAR_W-1:0] CH_SQUOTE   = 16'h0027;
	localparam logic [CHAR_W-1:0] CH_RND_OPEN = 16'h0028;
	localparam logic [CHAR_W-1:0] CH_RND_CLS  = 16'h0029;
	localparam logic [CHAR_W-1:0] CH_SQR_OPEN = 16'h005B;
	localparam logic [CHAR_W-1:0] CH_SQR_CLS  = 16'h005D;
	localparam logic [CHAR_W-1:0] CH_CRL_OPEN = 16'h007B;
	localparam logic [CHAR_W-1:0] CH_CRL_CLS  = 16'h007D;

	// Per-cycle command to every stack cell.
	typedef struct packed {
		logic push;
		logic pop;
		sym_t sym;
	} stack_op_t;

	function automatic sym_t open_kind(input logic [CHAR_W-1:0] c);
		sym_t k;
		unique case (c)
			CH_RND_OPEN: k = SYM_ROUND;
			CH_SQR_OPEN: k = SYM_SQUARE;
			CH_CRL_OPEN: k = SYM_CURLY;
			default:     k = SYM_NONE;
		endcase
		return k;
	endfunction

	function automatic sym_t close_kind(input logic [CHAR_W-1:0] c);
		sym_t k;
		unique case (c)
			CH_RND_CLS: k = SYM_ROUND;
			CH_SQR_CLS: k = SYM_SQUARE;
			CH_CRL_CLS: k = SYM_CURLY;
			default:    k = SYM_NONE;
		endcase
		return k;
	endfunction

	function automatic sym_t quote_kind(input logic [CHAR_W-1:0] c);
		sym_t k;
		unique case (c)
			CH_DQUOTE: k = SYM_DQUOTE;
			CH_SQUOTE: k = SYM_SQUOTE;
			default:   k = SYM_NONE;
		endcase
		return k;
	endfunction

endpackage

[src/qabm_char_if.sv]
// Character channel: one text character per beat.
interface qabm_char_if;
	logic                            valid;
	logic                            ready;
	logic [qabm_pkg::CHAR_W-1:0]     character;
	logic [qabm_pkg::POS_W-1:0]      char_position;
	logic                            start_search;
	logic                            backward;
	logic                            end_of_text;

	modport source (
		output valid, character, char_position, start_search, backward, end_of_text,
		input  ready
	);
	modport sink (
		input  valid, character, char_position, start_search, backward, end_of_text,
		output ready
	);
endinterface

[src/qabm_result_if.sv]
// Result channel: one search result per beat.
interface qabm_result_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic [qabm_pkg::POS_W-1:0]  match_position;

	modport source (
		output valid, status, match_position,
		input  ready
	);
	modport sink (
		input  valid, status, match_position,
		output ready
	);
endinterface

[src/qabm_cell.sv]
// One stack entry: loads from the cell above on push, from below on pop.
module qabm_cell (
	input  logic                clk,
	input  qabm_pkg::stack_op_t op,
	input  qabm_pkg::sym_t      from_above,
	input  qabm_pkg::sym_t      from_below,
	output qabm_pkg::sym_t      data
);

	qabm_pkg::sym_t data_q;

	always_ff @(posedge clk) begin
		priority if (op.push) begin
			data_q <= from_above;
		end else if (op.pop) begin
			data_q <= from_below;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;

endmodule

[src/quote_aware_bracket_matcher_core.sv]
// Quote-aware bracket matcher top level: search control and shift-stack of cells.
// Throughput: one character per cycle while the result register is free or drained;
// input stalls while a result waits and the result channel is not ready.
// Latency: a result is valid on the cycle after the character that causes it.
// The stack is a row of cells; top of stack is cell 0, read directly each cycle.
// Reset clears search state, stack depth and the output valid flag; cells are not reset.
module quote_aware_bracket_matcher_core #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	qabm_char_if.sink     chars,
	qabm_result_if.source results
);

	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

	logic                 searching_q;
	logic                 scan_backward_q;
	logic [DW-1:0]        depth_q;
	logic                 out_valid_q;
	qabm_pkg::status_t    status_q;
	logic [qabm_pkg::POS_W-1:0] pos_q;

	logic                 accept;
	logic                 active;
	logic                 dir;
	logic [DW-1:0]        depth_eff;
	logic                 nonempty;
	logic                 full;
	qabm_pkg::sym_t       top;
	qabm_pkg::sym_t       quote;
	qabm_pkg::sym_t       lead;
	qabm_pkg::sym_t       trail;
	logic                 do_push;
	logic                 do_pop;
	qabm_pkg::sym_t       push_sym;
	logic                 has_result;
	qabm_pkg::status_t    res_status;
	logic [qabm_pkg::POS_W-1:0] res_pos;
	logic [DW-1:0]        depth_next;
	qabm_pkg::stack_op_t  op;
	qabm_pkg::sym_t       stack_sym [STACK_DEPTH];

	assign chars.ready = !out_valid_q || results.ready;
	assign accept      = chars.valid && chars.ready;

	assign active    = chars.start_search || searching_q;
	assign dir       = chars.start_search ? chars.backward : scan_backward_q;
	assign depth_eff = chars.start_search ? '0 : depth_q;
	assign nonempty  = depth_eff != '0;
	assign full      = depth_eff == DW'(STACK_DEPTH);
	assign top       = stack_sym[0];
	assign quote     = qabm_pkg::quote_kind(chars.character);
	assign lead      = dir ? qabm_pkg::close_kind(chars.character)
	                       : qabm_pkg::open_kind(chars.character);
	assign trail     = dir ? qabm_pkg::open_kind(chars.character)
	                       : qabm_pkg::close_kind(chars.character);

	always_comb begin
		do_push    = 1'b0;
		do_pop     = 1'b0;
		push_sym   = lead;
		has_result = 1'b0;
		res_status = qabm_pkg::ST_END_OF_TEXT;
		res_pos    = '0;
		if (active) begin
			if (quote != qabm_pkg::SYM_NONE) begin
				push_sym = quote;
				if (nonempty && top == quote) begin
					do_pop = 1'b1;
				end else if (full) begin
					has_result = 1'b1;
					res_status = qabm_pkg::ST_OVERFLOW;
				end else begin
					do_push = 1'b1;
				end
			end else if (nonempty && (top == qabm_pkg::SYM_DQUOTE ||
			                          top == qabm_pkg::SYM_SQUOTE)) begin
				// inside a quoted run: brackets do not count
			end else if (lead != qabm_pkg::SYM_NONE) begin
				if (full) begin
					has_result = 1'b1;
					res_status = qabm_pkg::ST_OVERFLOW;
				end else begin
					do_push = 1'b1;
				end
			end else if (trail != qabm_pkg::SYM_NONE) begin
				if (!nonempty) begin
					has_result = 1'b1;
					res_status = qabm_pkg::ST_UNBALANCED;
				end else begin
					do_pop = 1'b1;
					if (depth_eff == DW'(1)) begin
						has_result = 1'b1;
						res_status = (top == trail) ? qabm_pkg::ST_MATCHED
						                            : qabm_pkg::ST_WRONG_KIND;
						res_pos    = chars.char_position;
					end
				end
			end
			if (!has_result && chars.end_of_text) begin
				has_result = 1'b1;
				res_status = qabm_pkg::ST_END_OF_TEXT;
			end
		end
	end

	always_comb begin
		depth_next = depth_eff;
		if (do_push) begin
			depth_next = depth_eff + DW'(1);
		end else if (do_pop) begin
			depth_next = depth_eff - DW'(1);
		end
	end

	assign op.push = accept && do_push;
	assign op.pop  = accept && do_pop;
	assign op.sym  = push_sym;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		qabm_pkg::sym_t above;
		qabm_pkg::sym_t below;
		if (i == 0) begin : g_top
			assign above = op.sym;
		end else begin : g_mid
			assign above = stack_sym[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = stack_sym[i];
		end else begin : g_inner
			assign below = stack_sym[i+1];
		end
		qabm_cell u_cell (
			.clk        (clk),
			.op         (op),
			.from_above (above),
			.from_below (below),
			.data       (stack_sym[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q     <= 1'b0;
			scan_backward_q <= 1'b0;
			depth_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				searching_q     <= active && !has_result;
				scan_backward_q <= dir;
				depth_q         <= depth_next;
			end
			if (accept && has_result) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_result) begin
			status_q <= res_status;
			pos_q    <= res_pos;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.status         = status_q;
	assign results.match_position = pos_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_result_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		accept && has_result |=> !searching_q && out_valid_q)
		else $error("search still active after its result");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		op.push |-> !full && !op.pop)
		else $error("push into full stack or with pop");

	a_match_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && has_result && (res_status == qabm_pkg::ST_MATCHED ||
		                         res_status == qabm_pkg::ST_WRONG_KIND)
		|-> depth_eff == DW'(1) && do_pop)
		else $error("match reported while stack not at last entry");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !active |=> depth_q == $past(depth_q) && !searching_q)
		else $error("idle character changed search state");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the quote-aware bracket matcher core.
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned DEPTH    = 64;
	localparam int          N_RANDOM = 1700;
	localparam int          HOLD_LEN = 300;
	localparam int unsigned CHAR_W   = qabm_pkg::CHAR_W;
	localparam int unsigned POS_W    = qabm_pkg::POS_W;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  pos;
		logic              start;
		logic              bwd;
		logic              eot;
	} char_beat_t;

	typedef struct packed {
		qabm_pkg::status_t st;
		logic [POS_W-1:0]  mpos;
	} search_result_t;

	typedef struct packed {
		char_beat_t     beat;
		logic           typed;
		search_result_t res;
	} script_row_t;

	// Directed searches; typed rows carry the answer, the rest go through the predictor.
	localparam script_row_t SCRIPT [0:24] = '{
		'{'{16'h0078, 31'd5, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_RND_OPEN, 31'd0, 1'b1, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_RND_CLS, POS_MAX, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{qabm_pkg::ST_MATCHED, POS_MAX}},
		'{'{qabm_pkg::CH_SQR_OPEN, 31'd10, 1'b1, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_RND_CLS, 31'd11, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{qabm_pkg::ST_WRONG_KIND, 31'd11}},
		'{'{16'h0000, 31'd12, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_CRL_CLS, 31'd20, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{qabm_pkg::ST_UNBALANCED, 31'd0}},
		'{'{qabm_pkg::CH_CRL_OPEN, 31'd30, 1'b1, 1'b0, 1'b1}, 1'b1,
			'{qabm_pkg::ST_END_OF_TEXT, 31'd0}},
		'{'{qabm_pkg::CH_CRL_CLS, 31'd100, 1'b1, 1'b1, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_DQUOTE, 31'd99, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_CRL_OPEN, 31'd98, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_DQUOTE, 31'd97, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_CRL_OPEN, 31'd96, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{qabm_pkg::ST_MATCHED, 31'd96}},
		'{'{qabm_pkg::CH_SQR_CLS, 31'd200, 1'b1, 1'b1, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_RND_OPEN, 31'd199, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{qabm_pkg::ST_WRONG_KIND, 31'd199}},
		'{'{qabm_pkg::CH_RND_OPEN, 31'd300, 1'b1, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_SQUOTE, 31'd301, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_RND_OPEN, 31'd310, 1'b1, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_DQUOTE, 31'd311, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_SQUOTE, 31'd312, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_DQUOTE, 31'd313, 1'b0, 1'b0, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{16'hFFFF, 31'd314, 1'b0, 1'b0, 1'b1}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{16'h0041, POS_MAX, 1'b1, 1'b1, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_RND_CLS, 31'h7FFF_FFFE, 1'b0, 1'b1, 1'b0}, 1'b0,
			'{qabm_pkg::ST_MATCHED, 31'd0}},
		'{'{qabm_pkg::CH_RND_OPEN, 31'd0, 1'b0, 1'b0, 1'b1}, 1'b1,
			'{qabm_pkg::ST_MATCHED, 31'd0}}
	};

	logic clk;
	logic arst_n;

	qabm_char_if   chars ();
	qabm_result_if results ();

	quote_aware_bracket_matcher_core #(.STACK_DEPTH(DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.results (results)
	);

	// predictor state
	qabm_pkg::sym_t sym_stack [0:DEPTH-1];
	int   stack_level;
	bit   searching;
	bit   scan_bwd;

	search_result_t pending_results [$];
	int mismatches;
	int processed;
	int send_gap_pct;
	bit calm;
	bit hold_req;
	bit hold_issued;
	bit holding;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic qabm_pkg::sym_t bracket_of(input logic [CHAR_W-1:0] ch,
	                                              input bit opening);
		qabm_pkg::sym_t k;
		case (ch)
			qabm_pkg::CH_RND_OPEN: k = opening ? qabm_pkg::SYM_ROUND  : qabm_pkg::SYM_NONE;
			qabm_pkg::CH_SQR_OPEN: k = opening ? qabm_pkg::SYM_SQUARE : qabm_pkg::SYM_NONE;
			qabm_pkg::CH_CRL_OPEN: k = opening ? qabm_pkg::SYM_CURLY  : qabm_pkg::SYM_NONE;
			qabm_pkg::CH_RND_CLS:  k = opening ? qabm_pkg::SYM_NONE   : qabm_pkg::SYM_ROUND;
			qabm_pkg::CH_SQR_CLS:  k = opening ? qabm_pkg::SYM_NONE   : qabm_pkg::SYM_SQUARE;
			qabm_pkg::CH_CRL_CLS:  k = opening ? qabm_pkg::SYM_NONE   : qabm_pkg::SYM_CURLY;
			default:               k = qabm_pkg::SYM_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [CHAR_W-1:0] char_for(input qabm_pkg::sym_t kind,
	                                               input bit opening);
		logic [CHAR_W-1:0] c;
		case (kind)
			qabm_pkg::SYM_SQUARE: c = opening ? qabm_pkg::CH_SQR_OPEN : qabm_pkg::CH_SQR_CLS;
			qabm_pkg::SYM_CURLY:  c = opening ? qabm_pkg::CH_CRL_OPEN : qabm_pkg::CH_CRL_CLS;
			default:              c = opening ? qabm_pkg::CH_RND_OPEN : qabm_pkg::CH_RND_CLS;
		endcase
		return c;
	endfunction

	// One character through the matcher; returns 1 when it ends the search.
	function automatic bit scan_char(input char_beat_t b, output search_result_t res);
		qabm_pkg::sym_t top, quote, lead, trail;
		bit   done;
		top  = qabm_pkg::SYM_NONE;
		done = 1'b0;
		res  = '{qabm_pkg::ST_MATCHED, '0};
		if (b.start) begin
			stack_level = 0;
			searching   = 1'b1;
			scan_bwd    = b.bwd;
		end
		if (!searching)
			return 1'b0;
		if (stack_level > 0)
			top = sym_stack[stack_level-1];
		quote = (b.ch == qabm_pkg::CH_DQUOTE) ? qabm_pkg::SYM_DQUOTE :
		        (b.ch == qabm_pkg::CH_SQUOTE) ? qabm_pkg::SYM_SQUOTE : qabm_pkg::SYM_NONE;
		// leading kind opens in scan direction, trailing kind closes
		lead  = bracket_of(b.ch, !scan_bwd);
		trail = bracket_of(b.ch, scan_bwd);
		if (quote != qabm_pkg::SYM_NONE) begin
			if (stack_level > 0 && top == quote) begin
				stack_level--;
			end else if (stack_level >= DEPTH) begin
				res.st = qabm_pkg::ST_OVERFLOW;
				done   = 1'b1;
			end else begin
				sym_stack[stack_level] = quote;
				stack_level++;
			end
		end else if (stack_level > 0 && (top == qabm_pkg::SYM_DQUOTE ||
		                                 top == qabm_pkg::SYM_SQUOTE)) begin
			// inside a quote: brackets are text
		end else if (lead != qabm_pkg::SYM_NONE) begin
			if (stack_level >= DEPTH) begin
				res.st = qabm_pkg::ST_OVERFLOW;
				done   = 1'b1;
			end else begin
				sym_stack[stack_level] = lead;
				stack_level++;
			end
		end else if (trail != qabm_pkg::SYM_NONE) begin
			if (stack_level == 0) begin
				res.st = qabm_pkg::ST_UNBALANCED;
				done   = 1'b1;
			end else begin
				stack_level--;
				if (stack_level == 0) begin
					res.st   = (top == trail) ? qabm_pkg::ST_MATCHED : qabm_pkg::ST_WRONG_KIND;
					res.mpos = b.pos;
					done     = 1'b1;
				end
			end
		end
		if (!done && b.eot) begin
			res.st = qabm_pkg::ST_END_OF_TEXT;
			done   = 1'b1;
		end
		if (done)
			searching = 1'b0;
		return done;
	endfunction

	// Offer one beat, record its expected result once taken, then maybe idle.
	task automatic drive_char(input char_beat_t b, input bit typed,
	                          input search_result_t typed_res);
		search_result_t res;
		chars.valid         <= 1'b1;
		chars.character     <= b.ch;
		chars.char_position <= b.pos;
		chars.start_search  <= b.start;
		chars.backward      <= b.bwd;
		chars.end_of_text   <= b.eot;
		@(negedge clk);
		while (chars.ready !== 1'b1)
			@(negedge clk);
		if (b.start || searching)
			processed++;
		if (scan_char(b, res))
			pending_results.push_back(typed ? typed_res : res);
		@(posedge clk);
		if (!calm && !holding && $urandom_range(0, 99) < send_gap_pct) begin
			chars.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// result sink: random stall bursts, one long hold-off to back up the block
	initial begin
		int seg;
		int stall_pct;
		seg = 0;
		stall_pct = 0;
		results.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (seg == 0) begin
				seg = 100;
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 8;
					default: stall_pct = 30;
				endcase
			end
			seg--;
			if (hold_req && !holding) begin
				holding = 1'b1;
				results.ready <= 1'b0;
				for (int n = 0; n < HOLD_LEN; n++)
					@(posedge clk);
				hold_req = 1'b0;
				holding  = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				results.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		search_result_t want;
		forever begin
			@(negedge clk);
			if (results.valid === 1'b1 && results.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d pos %0d",
						results.status, results.match_position));
				end else begin
					want = pending_results.pop_front();
					if (results.status !== want.st)
						report_mismatch($sformatf("status %0d, want %0d",
							results.status, want.st));
					if (results.match_position !== want.mpos)
						report_mismatch($sformatf("match_position %0d, want %0d",
							results.match_position, want.mpos));
				end
			end
		end
	end

	initial begin
		char_beat_t     beat;
		qabm_pkg::sym_t k;
		bit             bwd;
		int             mode;
		int             len;
		int             deep_n;
		int             pick;
		int             waited;
		mismatches = 0;
		processed  = 0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		hold_issued = 1'b0;
		holding    = 1'b0;
		searching  = 1'b0;
		scan_bwd   = 1'b0;
		stack_level = 0;
		send_gap_pct = 10;
		chars.valid         <= 1'b0;
		chars.character     <= '0;
		chars.char_position <= '0;
		chars.start_search  <= 1'b0;
		chars.backward      <= 1'b0;
		chars.end_of_text   <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		@(posedge clk);

		foreach (SCRIPT[i])
			drive_char(SCRIPT[i].beat, SCRIPT[i].typed, SCRIPT[i].res);

		processed = 0;
		while (processed < N_RANDOM) begin
			if (processed >= 600 && !hold_issued) begin
				hold_req    = 1'b1;
				hold_issued = 1'b1;
			end
			if (processed >= N_RANDOM - 150)
				calm = 1'b1;
			case ($urandom_range(0, 2))
				0: send_gap_pct = 0;
				1: send_gap_pct = 8;
				default: send_gap_pct = 30;
			endcase
			bwd  = 1'($urandom_range(0, 1));
			mode = $urandom_range(0, 39);
			if (mode < 3) begin
				// broken traffic: random fields, random starts and ends
				repeat ($urandom_range(1, 4)) begin
					beat.ch    = CHAR_W'($urandom);
					beat.pos   = POS_W'($urandom);
					beat.start = ($urandom_range(0, 3) == 0);
					beat.bwd   = 1'($urandom_range(0, 1));
					beat.eot   = ($urandom_range(0, 3) == 0);
					drive_char(beat, 1'b0, '0);
				end
			end else begin
				// searches; the deep ones push toward (and past) a full stack
				deep_n = (mode < 7) ? $urandom_range(DEPTH - 4, DEPTH + 2) : 0;
				len    = 0;
				beat.pos   = POS_W'($urandom);
				beat.start = 1'b1;
				beat.bwd   = bwd;
				beat.eot   = ($urandom_range(0, 49) == 0);
				k = qabm_pkg::sym_t'($urandom_range(1, 3));
				case ($urandom_range(0, 19))
					0: beat.ch = char_for(k, bwd);
					1: beat.ch = ($urandom_range(0, 1) != 0) ? qabm_pkg::CH_DQUOTE
					                                         : qabm_pkg::CH_SQUOTE;
					2: beat.ch = CHAR_W'($urandom);
					default: beat.ch = char_for(k, !bwd);
				endcase
				drive_char(beat, 1'b0, '0);
				beat.start = 1'b0;
				while (searching) begin
					len++;
					beat.pos = bwd ? beat.pos - 1'b1 : beat.pos + 1'b1;
					beat.bwd = 1'($urandom_range(0, 1));
					k = qabm_pkg::sym_t'($urandom_range(1, 3));
					pick = $urandom_range(0, 99);
					if (len < deep_n) begin
						beat.ch = char_for(k, !bwd);
					end else if (pick < 25) begin
						beat.ch = char_for(k, !bwd);
					end else if (pick < 55) begin
						// mostly close what is open
						if (stack_level > 0 && sym_stack[stack_level-1] inside
								{qabm_pkg::SYM_ROUND, qabm_pkg::SYM_SQUARE,
								 qabm_pkg::SYM_CURLY} &&
								$urandom_range(0, 99) < 85)
							k = sym_stack[stack_level-1];
						beat.ch = char_for(k, bwd);
					end else if (pick < 65) begin
						beat.ch = ($urandom_range(0, 1) != 0) ? qabm_pkg::CH_DQUOTE
						                                      : qabm_pkg::CH_SQUOTE;
					end else if (pick < 93) begin
						beat.ch = CHAR_W'($urandom_range(16'h20, 16'h7E));
					end else begin
						beat.ch = CHAR_W'($urandom);
					end
					beat.eot = (len >= 48 + deep_n) || ($urandom_range(0, 59) == 0);
					drive_char(beat, 1'b0, '0);
				end
				// text past the end of a search is ignored
				repeat ($urandom_range(0, 2)) begin
					beat.ch  = CHAR_W'($urandom);
					beat.pos = POS_W'($urandom);
					beat.bwd = 1'($urandom_range(0, 1));
					beat.eot = 1'($urandom_range(0, 1));
					drive_char(beat, 1'b0, '0);
				end
			end
		end

		calm = 1'b1;
		chars.valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		while (pending_results.size() != 0) begin
			void'(pending_results.pop_front());
			report_mismatch("expected result never arrived");
		end
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
